[rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define CHECK_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define CHECK_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fdss_pkg.sv]
package fdss_pkg;

  localparam logic [39:0] PIN_MAP_RESET = 40'h398A418820;
  localparam logic [13:0] MAX_SHOWN = 14'd9999;

  localparam logic REQ_SET  = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [13:0] display_value;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  digit_select;
    logic [31:0] segment_pins;
    logic [1:0]  scan_digit;
    logic        value_clamped;
  } out_item_t;

  // four bcd digits, index 0 is units
  typedef logic [3:0][3:0] digits_t;

  // standard seven-segment patterns, segment a in bit 0
  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] pat;
    case (digit)
      4'd0: pat = 8'h3f;
      4'd1: pat = 8'h06;
      4'd2: pat = 8'h5b;
      4'd3: pat = 8'h4f;
      4'd4: pat = 8'h66;
      4'd5: pat = 8'h6d;
      4'd6: pat = 8'h7d;
      4'd7: pat = 8'h07;
      4'd8: pat = 8'h7f;
      4'd9: pat = 8'h6f;
      default: pat = 8'h00;
    endcase
    return pat;
  endfunction

endpackage

[rtl/fdss_digit_split.sv]
module fdss_digit_split (
  input  logic [13:0]      value,
  output fdss_pkg::digits_t digits,
  output logic             clamped
);

  logic [13:0] sat;
  logic [9:0]  rem_k;
  logic [6:0]  rem_h;
  logic [3:0]  rem_t;

  // each digit: parallel compares against the multiples, pick the highest that fits
  always_comb begin
    clamped = (value > fdss_pkg::MAX_SHOWN);
    sat     = clamped ? fdss_pkg::MAX_SHOWN : value;

    digits[3] = 4'd0;
    rem_k     = sat[9:0];
    for (int k = 1; k < 10; k++) begin
      if (sat >= 14'(k * 1000)) begin
        digits[3] = 4'(k);
        rem_k     = 10'(sat - 14'(k * 1000));
      end
    end

    digits[2] = 4'd0;
    rem_h     = rem_k[6:0];
    for (int k = 1; k < 10; k++) begin
      if (rem_k >= 10'(k * 100)) begin
        digits[2] = 4'(k);
        rem_h     = 7'(rem_k - 10'(k * 100));
      end
    end

    digits[1] = 4'd0;
    rem_t     = rem_h[3:0];
    for (int k = 1; k < 10; k++) begin
      if (rem_h >= 7'(k * 10)) begin
        digits[1] = 4'(k);
        rem_t     = 4'(rem_h - 7'(k * 10));
      end
    end

    digits[0] = rem_t;
  end

endmodule

[rtl/fdss_pin_place.sv]
module fdss_pin_place (
  input  logic [39:0] pin_map,
  input  logic [7:0]  pattern,
  output logic [31:0] pins
);

  // later segments overwrite earlier ones on a shared pin
  always_comb begin
    pins = '0;
    for (int p = 0; p < 32; p++) begin
      for (int s = 0; s < 8; s++) begin
        if (pin_map[5*s +: 5] == 5'(p)) begin
          pins[p] = pattern[s];
        end
      end
    end
  end

endmodule

[rtl/four_digit_seven_segment_scan.sv]
// channel  | handshake               | payload
// ---------+-------------------------+----------------------------------------
// in       | in_valid / in_ready     | in_data  (req_type, display_value)
// out      | out_valid / out_ready   | out_data (digit_select, segment_pins,
//          |                         |           scan_digit, value_clamped)
// cfg      | cfg_we                  | cfg_wdata (segment_pin_map, 40 bits)
//
// an item is registered on entry and its result when it advances to the output
// register; one item per cycle sustained while out_ready stays high, set by
// the single compute stage between the input and result registers.
// reset clears digits, scan position, clamp flag and loads the default pin map.
// a stalled result holds in the output register; the input register keeps
// taking items until it too is full.
`include "assert_macros.svh"

module four_digit_seven_segment_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fdss_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output fdss_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [39:0]         cfg_wdata
);

  logic [39:0]        pin_map;
  fdss_pkg::digits_t  digits;
  logic [1:0]         scan_pos;
  logic               clamp;

  logic               s1_valid;
  fdss_pkg::in_item_t s1_data;

  logic               out_load;
  logic               s1_adv;

  fdss_pkg::digits_t  split_digits;
  logic               split_clamp;
  fdss_pkg::digits_t  digits_next;
  logic [1:0]         scan_pos_next;
  logic               clamp_next;
  logic [7:0]         pattern;
  logic [31:0]        pins;

  assign out_load = !out_valid || out_ready;
  assign s1_adv   = s1_valid && out_load;
  assign in_ready = !s1_valid || out_load;

  fdss_digit_split u_split (
    .value   (s1_data.display_value),
    .digits  (split_digits),
    .clamped (split_clamp)
  );

  always_comb begin
    if (s1_data.req_type == fdss_pkg::REQ_SET) begin
      digits_next   = split_digits;
      clamp_next    = split_clamp;
      scan_pos_next = scan_pos;
    end else begin
      digits_next   = digits;
      clamp_next    = clamp;
      scan_pos_next = scan_pos + 2'd1;
    end
    pattern = fdss_pkg::seg_pattern(digits_next[scan_pos_next]);
  end

  fdss_pin_place u_place (
    .pin_map (pin_map),
    .pattern (pattern),
    .pins    (pins)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_map <= fdss_pkg::PIN_MAP_RESET;
    end else if (cfg_we) begin
      pin_map <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digits   <= '0;
      scan_pos <= 2'd0;
      clamp    <= 1'b0;
    end else if (s1_adv) begin
      digits   <= digits_next;
      scan_pos <= scan_pos_next;
      clamp    <= clamp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.digit_select  <= ~(4'b0001 << scan_pos_next);
      out_data.segment_pins  <= pins;
      out_data.scan_digit    <= scan_pos_next;
      out_data.value_clamped <= clamp_next;
    end
  end

  `CHECK_ALWAYS(a_sel_matches_pos, clk, rst,
    !out_valid || (out_data.digit_select == ~(4'b0001 << out_data.scan_digit)),
    "digit select does not match scan digit")
  `CHECK_ALWAYS(a_digits_bcd, clk, rst,
    (digits[0] <= 4'd9) && (digits[1] <= 4'd9) && (digits[2] <= 4'd9) && (digits[3] <= 4'd9),
    "stored digit out of decimal range")
  `CHECK_NEXT(a_adv_fills_out, clk, rst, s1_adv, out_valid,
    "advanced item did not reach the result register")
  `CHECK_NEXT(a_tick_steps, clk, rst, s1_adv && (s1_data.req_type == fdss_pkg::REQ_TICK),
    scan_pos == 2'($past(scan_pos) + 2'd1), "tick did not advance scan position")

endmodule
